/* hw/rtl/ucs2u8_pkg.sv */
// Shared constants, types and helper functions of the UCS-2 name to UTF-8 converter.
`timescale 1ns / 1ps
`default_nettype none

package ucs2u8_pkg;

   localparam int CODE_WIDTH             = 16;
   localparam int BYTE_WIDTH             = 8;
   localparam int LEN_WIDTH              = 13;
   localparam int CSR_INDEX_WIDTH        = 2;
   localparam int MAX_RESULTS            = 5;
   localparam int RESULT_COUNT_WIDTH     = 3;
   localparam int DEFAULT_MAX_NAME_BYTES = 4096;
   localparam int RESET_BUDGET_LIMIT     = 4096;
   localparam int LEN_MAX                = 2 ** LEN_WIDTH - 1;

   localparam logic [CODE_WIDTH-1:0] ASCII_TOP     = 16'h007F;
   localparam logic [CODE_WIDTH-1:0] TWO_BYTE_TOP  = 16'h07FF;
   localparam logic [BYTE_WIDTH-1:0] CASE_BIT      = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_SEMI     = 8'h3B;
   localparam logic [BYTE_WIDTH-1:0] CHAR_PERIOD   = 8'h2E;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ONE      = 8'h31;
   localparam logic [BYTE_WIDTH-1:0] LEAD_TWO      = 8'hC0;
   localparam logic [BYTE_WIDTH-1:0] LEAD_THREE    = 8'hE0;
   localparam logic [BYTE_WIDTH-1:0] CONT_MARK     = 8'h80;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAX_OUT_BYTES = 2'd0,
      CSR_FOLD_CASE     = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] held0;
      logic [BYTE_WIDTH-1:0] held1;
      logic [1:0]            held_count;
      logic [LEN_WIDTH-1:0]  bytes_out;
      logic [LEN_WIDTH-1:0]  budget_left;
      logic                  stopped;
   } name_state_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][BYTE_WIDTH-1:0] bytes;
      logic [RESULT_COUNT_WIDTH-1:0]          count;
      logic                                   no_byte;
      logic                                   end_flag;
      logic [LEN_WIDTH-1:0]                   length;
   } enc_result_type;

   function automatic logic [BYTE_WIDTH-1:0] fold_byte(input logic [BYTE_WIDTH-1:0] b,
                                                       input logic enable);
      logic [BYTE_WIDTH-1:0] r;
      r = b;
      if (enable) begin
         if (b inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            r = b | CASE_BIT;
         end
         if (b == CHAR_SEMI) begin
            r = CHAR_PERIOD;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ucs2u8_if.sv */
// Channel interfaces of the converter: input code units, output bytes and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface ucs2u8_req_if import ucs2u8_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CODE_WIDTH-1:0] code_unit;
   logic                  last_unit;

   modport source(output valid, code_unit, last_unit, input ready);
   modport sink(input valid, code_unit, last_unit, output ready);
endinterface

interface ucs2u8_rsp_if import ucs2u8_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] out_byte;
   logic                  byte_valid;
   logic                  end_of_name;
   logic [LEN_WIDTH-1:0]  name_length;

   modport source(output valid, out_byte, byte_valid, end_of_name, name_length, input ready);
   modport sink(input valid, out_byte, byte_valid, end_of_name, name_length, output ready);
endinterface

interface ucs2u8_csr_if import ucs2u8_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [LEN_WIDTH-1:0]       data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ucs2_name_to_utf8_converter.sv */
// Top level of the UCS-2 file name to UTF-8 converter with version suffix removal.
//
// Code units of a name enter on req_if, one per transaction; last_unit closes the name.
// UTF-8 bytes leave on rsp_if, one per transaction. The transaction that closes a name
// carries end_of_name and name_length; if no byte is left to send at that point it
// carries byte_valid low. The user must write registers on csr_if (index 0: byte
// budget, index 1: case folding) only while no name work is in flight; the block
// does not enforce this, and csr_if is always ready. Throughput: one code unit per
// cycle while each unit yields at most one result and the receiver does not stall;
// a unit with several results holds the single result buffer until the byte-wide
// output port has sent them (up to five for the closing unit). The input register
// keeps taking a transaction while the result buffer drains its last entry. When
// the receiver stalls, the result buffer holds, then the input register fills and
// req_if.ready drops. Reset empties both stages, clears the name state, sets the
// budget to the smaller of MAX_NAME_BYTES and 4096, folding off.
`timescale 1ns / 1ps
`default_nettype none

module ucs2_name_to_utf8_converter import ucs2u8_pkg::*; #(
   parameter int MAX_NAME_BYTES = DEFAULT_MAX_NAME_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   ucs2u8_req_if.sink          req_if,
   ucs2u8_rsp_if.source        rsp_if,
   ucs2u8_csr_if.sink          csr_if
);

   localparam logic [LEN_WIDTH-1:0] BUDGET_CAP =
      LEN_WIDTH'((MAX_NAME_BYTES > LEN_MAX) ? LEN_MAX : MAX_NAME_BYTES);
   localparam logic [LEN_WIDTH-1:0] RESET_BUDGET =
      LEN_WIDTH'((MAX_NAME_BYTES > RESET_BUDGET_LIMIT) ? RESET_BUDGET_LIMIT : MAX_NAME_BYTES);

   logic                                   in_valid_ff;
   logic                                   in_valid_in;
   logic [CODE_WIDTH-1:0]                  in_code_ff;
   logic                                   in_last_ff;
   name_state_type                         state_ff;
   name_state_type                         state_in;
   name_state_type                         enc_state;
   enc_result_type                         enc_result;
   logic [LEN_WIDTH-1:0]                   budget_ff;
   logic [LEN_WIDTH-1:0]                   budget_in;
   logic                                   fold_ff;
   logic                                   fold_in;
   logic [MAX_RESULTS-1:0][BYTE_WIDTH-1:0] rbyte_ff;
   logic [MAX_RESULTS-1:0][BYTE_WIDTH-1:0] rbyte_in;
   logic [RESULT_COUNT_WIDTH-1:0]          rcnt_ff;
   logic [RESULT_COUNT_WIDTH-1:0]          rcnt_in;
   logic                                   nobyte_ff;
   logic                                   end_ff;
   logic [LEN_WIDTH-1:0]                   len_ff;
   logic                                   rsp_fire;
   logic                                   buf_free;
   logic                                   process;
   logic                                   csr_fire;
   logic [LEN_WIDTH-1:0]                   csr_budget;

   ucs2u8_encode u_encode (
      .state      (state_ff),
      .code_unit  (in_code_ff),
      .last_unit  (in_last_ff),
      .fold_case  (fold_ff),
      .max_budget (budget_ff),
      .next_state (enc_state),
      .result     (enc_result)
   );

   assign rsp_fire   = rsp_if.valid && rsp_if.ready;
   assign buf_free   = (rcnt_ff == '0) || ((rcnt_ff == 3'd1) && rsp_fire);
   assign process    = in_valid_ff && buf_free;
   assign csr_fire   = csr_if.valid && csr_if.ready;
   assign csr_budget = (csr_if.data > BUDGET_CAP) ? BUDGET_CAP : csr_if.data;

   assign req_if.ready       = !in_valid_ff || process;
   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid       = (rcnt_ff != '0);
   assign rsp_if.out_byte    = rbyte_ff[0];
   assign rsp_if.byte_valid  = !nobyte_ff;
   assign rsp_if.end_of_name = end_ff && (rcnt_ff == 3'd1);
   assign rsp_if.name_length = (end_ff && (rcnt_ff == 3'd1)) ? len_ff : '0;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
      end

      state_in = state_ff;
      if (process) begin
         state_in = enc_state;
      end

      budget_in = budget_ff;
      fold_in   = fold_ff;
      if (csr_fire) begin
         case (csr_if.index)
            CSR_MAX_OUT_BYTES: begin
               budget_in            = csr_budget;
               state_in.budget_left = csr_budget;
            end
            CSR_FOLD_CASE: begin
               fold_in = csr_if.data[0];
            end
            default: begin
            end
         endcase
      end

      rcnt_in  = rcnt_ff;
      rbyte_in = rbyte_ff;
      if (process) begin
         rcnt_in  = enc_result.count;
         rbyte_in = enc_result.bytes;
      end else if (rsp_fire) begin
         rcnt_in  = rcnt_ff - 3'd1;
         rbyte_in = {{BYTE_WIDTH{1'b0}}, rbyte_ff[MAX_RESULTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rcnt_ff     <= '0;
         budget_ff   <= RESET_BUDGET;
         fold_ff     <= 1'b0;
         state_ff    <= '{held0: '0, held1: '0, held_count: '0, bytes_out: '0,
                          budget_left: RESET_BUDGET, stopped: 1'b0};
      end else begin
         in_valid_ff <= in_valid_in;
         rcnt_ff     <= rcnt_in;
         budget_ff   <= budget_in;
         fold_ff     <= fold_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_code_ff <= req_if.code_unit;
         in_last_ff <= req_if.last_unit;
      end
      rbyte_ff <= rbyte_in;
      if (process) begin
         nobyte_ff <= enc_result.no_byte;
         end_ff    <= enc_result.end_flag;
         len_ff    <= enc_result.length;
      end
   end

   a_rcnt_range: assert property (@(posedge clock) disable iff (reset)
      rcnt_ff <= 3'd5)
      else $error("result buffer count out of range");

   a_held_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.held_count != 2'd3)
      else $error("held byte count out of range");

   a_name_restart: assert property (@(posedge clock) disable iff (reset)
      process && in_last_ff |=> (state_ff.held_count == 2'd0) && (state_ff.bytes_out == '0)
                                && !state_ff.stopped)
      else $error("name state not restarted after closing code unit");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && nobyte_ff |-> (rcnt_ff == 3'd1) && end_ff)
      else $error("byteless result that does not close a name");

endmodule

`default_nettype wire

/* hw/rtl/ucs2u8_encode.sv */
// Combinational encoder: one code unit and the name state in, result bytes and next state out.
`timescale 1ns / 1ps
`default_nettype none

module ucs2u8_encode import ucs2u8_pkg::*; (
   input  name_state_type        state,
   input  logic [CODE_WIDTH-1:0] code_unit,
   input  logic                  last_unit,
   input  logic                  fold_case,
   input  logic [LEN_WIDTH-1:0]  max_budget,
   output name_state_type        next_state,
   output enc_result_type        result
);

   always_comb begin
      logic                                   stop_n;
      logic                                   active;
      logic                                   fits;
      logic [1:0]                             need;
      logic [1:0]                             push_n;
      logic [BYTE_WIDTH-1:0]                  p0;
      logic [BYTE_WIDTH-1:0]                  p1;
      logic [BYTE_WIDTH-1:0]                  p2;
      logic [MAX_RESULTS-1:0][BYTE_WIDTH-1:0] seq;
      logic [RESULT_COUNT_WIDTH-1:0]          total;
      logic [RESULT_COUNT_WIDTH-1:0]          emit_n;
      logic [RESULT_COUNT_WIDTH-1:0]          count;
      logic [BYTE_WIDTH-1:0]                  h0_n;
      logic [BYTE_WIDTH-1:0]                  h1_n;
      logic [1:0]                             hc_n;
      logic [LEN_WIDTH-1:0]                   bytes_n;
      logic [LEN_WIDTH-1:0]                   budget_n;
      logic                                   drop;

      stop_n = state.stopped | (code_unit == '0);
      active = !stop_n && (state.budget_left != '0);

      if (code_unit <= ASCII_TOP) begin
         need = 2'd1;
         p0   = code_unit[BYTE_WIDTH-1:0];
         p1   = '0;
         p2   = '0;
      end else if (code_unit <= TWO_BYTE_TOP) begin
         need = 2'd2;
         p0   = LEAD_TWO | {3'b000, code_unit[10:6]};
         p1   = CONT_MARK | {2'b00, code_unit[5:0]};
         p2   = '0;
      end else begin
         need = 2'd3;
         p0   = LEAD_THREE | {4'b0000, code_unit[15:12]};
         p1   = CONT_MARK | {2'b00, code_unit[11:6]};
         p2   = CONT_MARK | {2'b00, code_unit[5:0]};
      end

      fits     = {{(LEN_WIDTH-2){1'b0}}, need} <= state.budget_left;
      push_n   = (active && fits) ? need : 2'd0;
      budget_n = state.budget_left;
      if (active) begin
         if (fits) begin
            budget_n = state.budget_left - {{(LEN_WIDTH-2){1'b0}}, need};
         end else begin
            budget_n = state.budget_left - {{(LEN_WIDTH-1){1'b0}}, 1'b1};
         end
      end

      seq = '0;
      case (state.held_count)
         2'd0: begin
            seq[0] = p0;
            seq[1] = p1;
            seq[2] = p2;
         end
         2'd1: begin
            seq[0] = state.held0;
            seq[1] = p0;
            seq[2] = p1;
            seq[3] = p2;
         end
         default: begin
            seq[0] = state.held0;
            seq[1] = state.held1;
            seq[2] = p0;
            seq[3] = p1;
            seq[4] = p2;
         end
      endcase

      total  = {1'b0, state.held_count} + {1'b0, push_n};
      emit_n = (total > 3'd2) ? (total - 3'd2) : 3'd0;

      if (total >= 3'd2) begin
         h0_n = seq[total - 3'd2];
         h1_n = seq[total - 3'd1];
         hc_n = 2'd2;
      end else if (total == 3'd1) begin
         h0_n = seq[0];
         h1_n = state.held1;
         hc_n = 2'd1;
      end else begin
         h0_n = state.held0;
         h1_n = state.held1;
         hc_n = 2'd0;
      end

      bytes_n = state.bytes_out + {{(LEN_WIDTH-2){1'b0}}, push_n};
      drop    = (bytes_n > 13'd2) && (hc_n == 2'd2) && (h0_n == CHAR_SEMI) &&
                (h1_n == CHAR_ONE);

      count = emit_n;
      if (last_unit) begin
         count = drop ? emit_n : total;
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         result.bytes[i] = fold_byte(seq[i], fold_case);
      end
      result.no_byte  = 1'b0;
      result.count    = count;
      result.end_flag = last_unit;
      result.length   = drop ? (bytes_n - 13'd2) : bytes_n;
      if (last_unit && (count == '0)) begin
         result.bytes[0] = '0;
         result.no_byte  = 1'b1;
         result.count    = 3'd1;
      end

      if (last_unit) begin
         next_state.held0       = '0;
         next_state.held1       = '0;
         next_state.held_count  = 2'd0;
         next_state.bytes_out   = '0;
         next_state.budget_left = max_budget;
         next_state.stopped     = 1'b0;
      end else begin
         next_state.held0       = h0_n;
         next_state.held1       = h1_n;
         next_state.held_count  = hc_n;
         next_state.bytes_out   = bytes_n;
         next_state.budget_left = budget_n;
         next_state.stopped     = stop_n;
      end
   end

endmodule

`default_nettype wire

/* bench/ucs2_name_to_utf8_converter_tb.sv */
// Self-checking testbench of the UCS-2 name to UTF-8 converter with random names and stalls.
`timescale 1ns / 1ps

module ucs2_name_to_utf8_converter_tb;
   import ucs2u8_pkg::*;

   localparam logic [LEN_WIDTH-1:0] NAME_BYTE_CAP = LEN_WIDTH'(DEFAULT_MAX_NAME_BYTES);
   localparam int DIRECTED_UNITS = 26;
   localparam int TOTAL_UNITS    = DIRECTED_UNITS + 420;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] code;
      logic                  last;
      logic                  drain_first;
   } name_unit_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] out_byte;
      logic                  byte_valid;
      logic                  end_of_name;
      logic [LEN_WIDTH-1:0]  name_length;
   } utf8_byte_type;

   logic clock = 1'b0;
   logic reset;

   ucs2u8_req_if req_if();
   ucs2u8_rsp_if rsp_if();
   ucs2u8_csr_if csr_if();

   ucs2_name_to_utf8_converter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   name_unit_type name_units[$];
   utf8_byte_type utf8_bytes_due[$];
   int units_queued    = 0;
   int units_in_flight = 0;
   int mismatches      = 0;
   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int send_gap;
   int rsp_stall;

   // Converter state as the block should hold it.
   logic [BYTE_WIDTH-1:0] held_lo;
   logic [BYTE_WIDTH-1:0] held_hi;
   logic [1:0]            held_n;
   logic [LEN_WIDTH-1:0]  produced;
   logic [LEN_WIDTH-1:0]  budget_left;
   logic [LEN_WIDTH-1:0]  budget_reg;
   logic                  fold_on;
   logic                  halted;
   int                    step_results;

   function automatic logic [LEN_WIDTH-1:0] budget_limit();
      return (budget_reg > NAME_BYTE_CAP) ? NAME_BYTE_CAP : budget_reg;
   endfunction

   function automatic void restart_name();
      held_lo     = '0;
      held_hi     = '0;
      held_n      = '0;
      produced    = '0;
      budget_left = budget_limit();
      halted      = 1'b0;
   endfunction

   function automatic void send_byte(input logic [BYTE_WIDTH-1:0] b);
      utf8_byte_type r;
      if (fold_on) begin
         if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) b = b | CASE_BIT;
         if (b == CHAR_SEMI) b = CHAR_PERIOD;
      end
      r.out_byte    = b;
      r.byte_valid  = 1'b1;
      r.end_of_name = 1'b0;
      r.name_length = '0;
      utf8_bytes_due.push_back(r);
      step_results++;
   endfunction

   function automatic void hold_byte(input logic [BYTE_WIDTH-1:0] b);
      if (held_n == 2'd2) begin
         send_byte(held_lo);
         held_lo = held_hi;
         held_hi = b;
      end else if (held_n == 2'd1) begin
         held_hi = b;
         held_n  = 2'd2;
      end else begin
         held_lo = b;
         held_n  = 2'd1;
      end
      produced++;
   endfunction

   function automatic void convert_unit(input logic [CODE_WIDTH-1:0] code, input logic last);
      int                   need;
      logic [LEN_WIDTH-1:0] len;
      utf8_byte_type        r;
      step_results = 0;
      if (!halted && code == '0) halted = 1'b1;
      if (!halted && budget_left > 0) begin
         need = (code <= ASCII_TOP) ? 1 : (code <= TWO_BYTE_TOP) ? 2 : 3;
         if (need > budget_left) begin
            budget_left--;
         end else begin
            budget_left = budget_left - LEN_WIDTH'(need);
            case (need)
               1: hold_byte(code[7:0]);
               2: begin
                  hold_byte(LEAD_TWO | {3'b000, code[10:6]});
                  hold_byte(CONT_MARK | {2'b00, code[5:0]});
               end
               default: begin
                  hold_byte(LEAD_THREE | {4'h0, code[15:12]});
                  hold_byte(CONT_MARK | {2'b00, code[11:6]});
                  hold_byte(CONT_MARK | {2'b00, code[5:0]});
               end
            endcase
         end
      end
      if (last) begin
         len = produced;
         if (len > 2 && held_n == 2'd2 && held_lo == CHAR_SEMI && held_hi == CHAR_ONE) begin
            len = len - LEN_WIDTH'(2);
         end else begin
            if (held_n >= 2'd1) send_byte(held_lo);
            if (held_n == 2'd2) send_byte(held_hi);
         end
         if (step_results == 0) begin
            r = '0;
         end else begin
            r = utf8_bytes_due[$];
            void'(utf8_bytes_due.pop_back());
         end
         r.end_of_name = 1'b1;
         r.name_length = len;
         utf8_bytes_due.push_back(r);
         restart_name();
      end
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : unit_driver
      name_unit_type nxt;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.code_unit <= '0;
         req_if.last_unit <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            convert_unit(req_if.code_unit, req_if.last_unit);
            units_in_flight--;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (name_units.size() == 0 ||
                         (name_units[0].drain_first && utf8_bytes_due.size() != 0)) begin
               req_if.valid <= 1'b0;
            end else if ($urandom_range(0, 99) < send_idle_pct) begin
               send_gap = $urandom_range(0, 16);
               req_if.valid <= 1'b0;
            end else begin
               nxt = name_units.pop_front();
               req_if.valid     <= 1'b1;
               req_if.code_unit <= nxt.code;
               req_if.last_unit <= nxt.last;
            end
         end
      end
   end

   always @(posedge clock) begin : byte_monitor
      utf8_byte_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (utf8_bytes_due.size() == 0) begin
               $display("%0t ns: unexpected transaction, expected none, actual byte 0x%0h valid %0b end %0b length %0d",
                        $time, rsp_if.out_byte, rsp_if.byte_valid, rsp_if.end_of_name,
                        rsp_if.name_length);
               mismatches++;
            end else begin
               want = utf8_bytes_due.pop_front();
               check_field("out_byte", want.out_byte, rsp_if.out_byte);
               check_field("byte_valid", want.byte_valid, rsp_if.byte_valid);
               check_field("end_of_name", want.end_of_name, rsp_if.end_of_name);
               check_field("name_length", want.name_length, rsp_if.name_length);
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall = $urandom_range(0, 16);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic queue_unit(input logic [CODE_WIDTH-1:0] code, input logic last,
                             input logic drain_first);
      name_unit_type u;
      u.code        = code;
      u.last        = last;
      u.drain_first = drain_first;
      name_units.push_back(u);
      units_queued++;
      units_in_flight++;
   endtask

   task automatic queue_name(input int n_units, input logic drain_first);
      logic [CODE_WIDTH-1:0] code;
      int                    pick;
      logic                  suffix;
      suffix = (n_units >= 2) && ($urandom_range(0, 99) < 35);
      for (int i = 0; i < n_units; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) code = CODE_WIDTH'($urandom_range(16'h0020, 16'h007E));
         else if (pick < 45) code = CODE_WIDTH'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
         else if (pick < 52) code = CODE_WIDTH'(CHAR_SEMI);
         else if (pick < 56) code = CODE_WIDTH'($urandom_range(1, ASCII_TOP));
         else if (pick < 70) code = CODE_WIDTH'($urandom_range(ASCII_TOP + 1, TWO_BYTE_TOP));
         else if (pick < 85) code = CODE_WIDTH'($urandom_range(TWO_BYTE_TOP + 1, 16'hFFFF));
         else if (pick < 90) code = CODE_WIDTH'($urandom_range(16'hD800, 16'hDFFF));
         else if (pick < 93) code = '0;
         else code = CODE_WIDTH'($urandom_range(0, 16'hFFFF));
         if (suffix && i == n_units - 2) code = CODE_WIDTH'(CHAR_SEMI);
         if (suffix && i == n_units - 1) code = CODE_WIDTH'(CHAR_ONE);
         queue_unit(code, i == n_units - 1, drain_first && i == 0);
      end
   endtask

   task automatic write_register(input csr_reg_type which, input logic [LEN_WIDTH-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= which;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (which == CSR_MAX_OUT_BYTES) begin
         budget_reg  = value;
         budget_left = budget_limit();
      end else if (which == CSR_FOLD_CASE) begin
         fold_on = value[0];
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (units_in_flight != 0 || utf8_bytes_due.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [LEN_WIDTH-1:0] budget;
      int                   n_units;
      logic                 first_random;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.code_unit = '0;
      req_if.last_unit = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = CSR_MAX_OUT_BYTES;
      csr_if.data      = '0;
      budget_reg       = NAME_BYTE_CAP;
      fold_on          = 1'b0;
      restart_name();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      queue_unit(CODE_WIDTH'(CHAR_UPPER_A), 1'b0, 1'b0);
      queue_unit(CODE_WIDTH'(CHAR_SEMI), 1'b0, 1'b0);
      queue_unit(CODE_WIDTH'(CHAR_ONE), 1'b1, 1'b0);
      queue_unit(CODE_WIDTH'(CHAR_SEMI), 1'b0, 1'b0);
      queue_unit(CODE_WIDTH'(CHAR_ONE), 1'b1, 1'b0);
      queue_unit(16'h0000, 1'b0, 1'b0);
      queue_unit(16'h0078, 1'b1, 1'b0);
      queue_unit(ASCII_TOP, 1'b0, 1'b1);
      queue_unit(ASCII_TOP + 16'd1, 1'b0, 1'b0);
      queue_unit(TWO_BYTE_TOP, 1'b0, 1'b0);
      queue_unit(TWO_BYTE_TOP + 16'd1, 1'b0, 1'b0);
      queue_unit(16'hD800, 1'b0, 1'b0);
      queue_unit(16'hFFFF, 1'b1, 1'b0);
      queue_unit(16'h0000, 1'b1, 1'b0);
      wait_idle();

      write_register(CSR_FOLD_CASE, 13'd1);
      queue_unit(16'h0061, 1'b0, 1'b0);
      queue_unit(16'h0051, 1'b0, 1'b0);
      queue_unit(CODE_WIDTH'(CHAR_SEMI), 1'b0, 1'b0);
      queue_unit(CODE_WIDTH'(CHAR_ONE), 1'b1, 1'b0);
      queue_unit(16'h004D, 1'b0, 1'b0);
      queue_unit(CODE_WIDTH'(CHAR_SEMI), 1'b0, 1'b0);
      queue_unit(CODE_WIDTH'(CHAR_UPPER_Z), 1'b1, 1'b0);
      wait_idle();

      write_register(CSR_MAX_OUT_BYTES, 13'h1FFF);
      write_register(CSR_MAX_OUT_BYTES, 13'd0);
      queue_unit(16'h0061, 1'b0, 1'b0);
      queue_unit(16'h0062, 1'b1, 1'b0);
      wait_idle();

      write_register(CSR_MAX_OUT_BYTES, 13'd2);
      write_register(CSR_FOLD_CASE, 13'd0);
      queue_unit(TWO_BYTE_TOP + 16'd1, 1'b0, 1'b0);
      queue_unit(16'h0061, 1'b0, 1'b0);
      queue_unit(16'h0062, 1'b1, 1'b0);
      wait_idle();

      first_random = 1'b1;
      while (units_queued < TOTAL_UNITS) begin
         case ($urandom_range(0, 9))
            0:          budget = '0;
            1:          budget = LEN_WIDTH'($urandom_range(1, 3));
            2, 3, 4, 5: budget = LEN_WIDTH'($urandom_range(4, 40));
            6, 7:       budget = NAME_BYTE_CAP;
            8:          budget = 13'h1FFF;
            default:    budget = LEN_WIDTH'($urandom_range(0, 13'h1FFF));
         endcase
         write_register(CSR_MAX_OUT_BYTES, budget);
         write_register(CSR_FOLD_CASE, LEN_WIDTH'($urandom_range(0, 1)));
         if (units_queued >= TOTAL_UNITS - 60) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            send_idle_pct = $urandom_range(0, 2) * 15;
            rsp_stall_pct = $urandom_range(0, 2) * 15;
         end
         for (int k = 0; k < 8 && units_queued < TOTAL_UNITS; k++) begin
            n_units = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 30)
                                                   : $urandom_range(1, 10);
            queue_name(n_units, first_random || $urandom_range(0, 9) == 0);
            first_random = 1'b0;
         end
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("ucs2_name_to_utf8_converter_tb OK");
      end else begin
         $display("ucs2_name_to_utf8_converter_tb NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("ucs2_name_to_utf8_converter_tb NOT OK");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/ucs2u8_pkg.sv
hw/rtl/ucs2u8_if.sv
hw/rtl/ucs2u8_encode.sv
hw/rtl/ucs2_name_to_utf8_converter.sv
bench/ucs2_name_to_utf8_converter_tb.sv
